// ----- hw/rtl/kml_pkg.sv -----
// ----------------------------------------------------------------------------
// kml_pkg: shared types and codes of the keyed move learning table
// Item layouts, operation and status codes, register indexes, FSM states.
// ----------------------------------------------------------------------------
package kml_pkg;

    localparam int unsigned KEY_W    = 64;
    localparam int unsigned MOVE_W   = 32;
    localparam int unsigned VAL_W    = 16;
    localparam int unsigned CNT_W    = 4;
    localparam int unsigned FLAG_W   = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [VAL_W-1:0]  DEFAULT_WEIGHT = 16'd50;
    localparam logic [FLAG_W-1:0] FLAG_CUSTOM    = 2'b01;
    localparam logic [FLAG_W-1:0] FLAG_MODIFIED  = 2'b10;

    typedef enum logic [2:0] {
        OP_LEARN      = 3'd0,
        OP_ADD        = 3'd1,
        OP_SET_WEIGHT = 3'd2,
        OP_REMOVE     = 3'd3,
        OP_QUERY      = 3'd4,
        OP_CLEAR      = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        ST_DONE       = 3'd0,
        ST_NOT_FOUND  = 3'd1,
        ST_TABLE_FULL = 3'd2,
        ST_ENTRY_FULL = 3'd3,
        ST_DISABLED   = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE  = 3'd0,
        CFG_WIN     = 3'd1,
        CFG_LOSS    = 3'd2,
        CFG_DRAW    = 3'd3,
        CFG_FLOOR   = 3'd4,
        CFG_CEILING = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]        op;
        logic [KEY_W-1:0]  position_key;
        logic [MOVE_W-1:0] move_code;
        logic [1:0]        game_result;
        logic signed [VAL_W-1:0] new_weight;
    } t_in_item;

    typedef struct packed {
        logic [2:0]              status;
        logic signed [VAL_W-1:0] learn_value;
    } t_out_item;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [CNT_W-1:0]  cnt;
        logic [FLAG_W-1:0] flags;
    } t_slot_ent;

    typedef struct packed {
        logic [MOVE_W-1:0] mv;
        logic [VAL_W-1:0]  weight;
        logic [VAL_W-1:0]  learn;
        logic [VAL_W-1:0]  games;
    } t_move_ent;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_MOD, S_PR_RD, S_PR_CHK, S_MV_RD, S_MV_CHK, S_NOMV, S_HIT,
        S_LEARN_ADD, S_LEARN_WR, S_RM_RD, S_RM_WR, S_CLR_RD, S_CLR_CHK, S_CLR_MV,
        S_CLR_MW, S_FIN
    } t_state;

endpackage

// ----- hw/rtl/kml_in_if.sv -----
// ----------------------------------------------------------------------------
// kml_in_if: request channel of the keyed move learning table
// Valid/ready handshake carrying one operation item.
// ----------------------------------------------------------------------------
interface kml_in_if;
    logic              valid;
    logic              ready;
    kml_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/kml_out_if.sv -----
// ----------------------------------------------------------------------------
// kml_out_if: result channel of the keyed move learning table
// Valid/ready handshake carrying one status item.
// ----------------------------------------------------------------------------
interface kml_out_if;
    logic               valid;
    logic               ready;
    kml_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/keyed_move_learning_table.sv -----
// ----------------------------------------------------------------------------
// keyed_move_learning_table: linear probing table of per-position move stats
// Learn, add, set weight, remove, query and clear over a slot/move store.
// ----------------------------------------------------------------------------
// Usage: i_in takes one operation item (valid/ready); o_out returns exactly
// one result item per operation. Registers are written on i_cfg_we with
// i_cfg_idx/i_cfg_data; the user must write them only while the block is idle,
// as the block itself does not enforce it.
// Sequence: every probing op first reduces the key modulo SLOTS 16 bits at a
// time, a quotient estimate then a subtract/correct step per chunk (shared
// reciprocal multiply/subtract), then probes slot by slot (registered slot
// memory read), scans the moves one by one and updates. Lookups stop at the
// first empty zero-key slot; learn/add scan all SLOTS slots when the key is
// new. Remove shifts each later move down one place. Clear visits every slot
// and each stored move. A disabled learn or unknown op goes straight to S_FIN.
// One item is in work at a time; i_in.ready is high only when idle.
// Reset: a clearing pass writes every slot to zero, with i_in.ready low;
// configuration returns to its defaults at once.
// Stall: a finished result waits in the output register; a new item may be
// accepted meanwhile, and its result waits until the previous one is taken.
// ----------------------------------------------------------------------------
module keyed_move_learning_table #(
    parameter int unsigned SLOTS          = 1024,
    parameter int unsigned MOVES_PER_SLOT = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [kml_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [kml_pkg::CFG_DAT_W-1:0]       i_cfg_data,
    kml_in_if.sink                              i_in,
    kml_out_if.source                           o_out
);

    localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned MD = SLOTS * MOVES_PER_SLOT;
    localparam int unsigned MW = (MD > 1) ? $clog2(MD) : 1;
    localparam int unsigned CW = kml_pkg::CNT_W;
    localparam int unsigned VW = kml_pkg::VAL_W;
    // floor(2^(32+IW) / SLOTS): quotient estimate is low by at most one
    localparam logic [32:0] RECIP = 33'((64'd1 << (32 + IW)) / 64'(SLOTS));

    // storage
    kml_pkg::t_slot_ent slot_mem [SLOTS];
    kml_pkg::t_move_ent move_mem [MD];

    kml_pkg::t_state    r_state, n_state;
    kml_pkg::t_in_item  r_in, n_in;
    logic [IW-1:0]      r_idx, n_idx;
    logic [IW-1:0]      r_visit, n_visit;
    logic [IW-1:0]      r_empty, n_empty;
    logic               r_empty_vld, n_empty_vld;
    logic [IW-1:0]      r_slot, n_slot;
    logic [CW-1:0]      r_scnt, n_scnt;
    logic [kml_pkg::FLAG_W-1:0] r_sflags, n_sflags;
    logic [CW-1:0]      r_j, n_j;
    kml_pkg::t_move_ent r_ent, n_ent;
    logic signed [VW+1:0] r_v, n_v;
    logic [IW-1:0]      r_mod, n_mod;
    logic [15:0]        r_q, n_q;
    logic [2:0]         r_bit, n_bit;
    logic [2:0]         r_st, n_st;
    logic signed [VW-1:0] r_lv, n_lv;
    logic               r_ov, n_ov;
    kml_pkg::t_out_item r_out, n_out;

    logic               r_en;
    logic [14:0]        r_win, r_loss;
    logic signed [VW-1:0] r_draw, r_floor, r_ceil;

    kml_pkg::t_slot_ent r_srd;
    kml_pkg::t_move_ent r_mrd;

    logic               slot_we;
    logic [IW-1:0]      slot_waddr, slot_raddr;
    kml_pkg::t_slot_ent slot_wdata;
    logic               mv_we;
    logic [MW-1:0]      mv_waddr, mv_raddr;
    kml_pkg::t_move_ent mv_wdata;

    logic [IW+15:0]     mod_t;
    logic [IW+48:0]     mod_prod;
    logic [IW+16:0]     mod_rem;
    logic [IW-1:0]      mod_r;
    logic [IW-1:0]      idx_next;
    logic               is_fm, slot_match, last_visit, empty_ok;
    logic [IW-1:0]      empty_now;
    logic [CW:0]        j_inc;
    logic [MW-1:0]      addr_j, addr_j1;
    logic signed [VW+1:0] delta, v_lo, v_cl;
    logic               out_free;

    // remainder so far followed by the current 16-bit key chunk
    always_comb begin
        mod_t    = {r_mod, r_in.position_key[{r_bit[2:1], 4'b0000} +: 16]};
        mod_prod = (IW+49)'(mod_t) * (IW+49)'(RECIP);
        mod_rem  = (IW+17)'(mod_t) - (IW+17)'(r_q) * (IW+17)'(SLOTS);
        mod_r    = (mod_rem >= (IW+17)'(SLOTS)) ? IW'(mod_rem - (IW+17)'(SLOTS))
                                                : IW'(mod_rem);
    end

    assign idx_next   = (r_idx == IW'(SLOTS - 1)) ? '0 : r_idx + 1'b1;
    assign is_fm      = (r_in.op == kml_pkg::OP_LEARN) || (r_in.op == kml_pkg::OP_ADD);
    assign slot_match = (r_srd.key == r_in.position_key) && (r_srd.cnt != '0);
    assign last_visit = (r_visit == IW'(SLOTS - 1));
    assign empty_ok   = r_empty_vld || (r_srd.cnt == '0);
    assign empty_now  = r_empty_vld ? r_empty : r_idx;
    assign j_inc      = {1'b0, r_j} + 1'b1;
    assign addr_j     = MW'(r_slot) * MW'(MOVES_PER_SLOT) + MW'(r_j);
    assign addr_j1    = addr_j + 1'b1;
    assign out_free   = !r_ov || o_out.ready;

    always_comb begin
        case (r_in.game_result)
            2'd0:    delta = (VW+2)'(signed'({1'b0, r_win}));
            2'd1:    delta = -(VW+2)'(signed'({1'b0, r_loss}));
            2'd2:    delta = (VW+2)'(r_draw);
            default: delta = '0;
        endcase
    end

    always_comb begin
        v_lo = (r_v < (VW+2)'(r_floor)) ? (VW+2)'(r_floor) : r_v;
        v_cl = (v_lo > (VW+2)'(r_ceil)) ? (VW+2)'(r_ceil) : v_lo;
    end

    assign i_in.ready  = (r_state == kml_pkg::S_IDLE);
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    always_comb begin
        n_state = r_state;     n_in = r_in;         n_idx = r_idx;
        n_visit = r_visit;     n_empty = r_empty;   n_empty_vld = r_empty_vld;
        n_slot = r_slot;       n_scnt = r_scnt;     n_sflags = r_sflags;
        n_j = r_j;             n_ent = r_ent;       n_v = r_v;
        n_mod = r_mod;         n_bit = r_bit;       n_st = r_st;
        n_lv = r_lv;           n_ov = r_ov;         n_out = r_out;
        n_q = r_q;
        slot_we = 1'b0;        slot_waddr = r_slot; slot_raddr = r_idx;
        slot_wdata = '{key: r_in.position_key, cnt: r_scnt, flags: r_sflags};
        mv_we = 1'b0;          mv_waddr = addr_j;   mv_raddr = addr_j;
        mv_wdata = r_ent;

        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            kml_pkg::S_INIT: begin
                slot_we    = 1'b1;
                slot_waddr = r_idx;
                slot_wdata = '0;
                n_idx      = idx_next;
                if (r_idx == IW'(SLOTS - 1)) begin
                    n_state = kml_pkg::S_IDLE;
                end
            end
            kml_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_in  = i_in.data;
                    n_st  = kml_pkg::ST_DONE;
                    n_lv  = '0;
                    n_idx = '0;
                    n_mod = '0;
                    n_bit = 3'd7;
                    case (i_in.data.op)
                        kml_pkg::OP_LEARN: begin
                            if (!r_en) begin
                                n_st    = kml_pkg::ST_DISABLED;
                                n_state = kml_pkg::S_FIN;
                            end else begin
                                n_state = kml_pkg::S_MOD;
                            end
                        end
                        kml_pkg::OP_ADD, kml_pkg::OP_SET_WEIGHT, kml_pkg::OP_REMOVE,
                        kml_pkg::OP_QUERY: n_state = kml_pkg::S_MOD;
                        kml_pkg::OP_CLEAR: n_state = kml_pkg::S_CLR_RD;
                        default:           n_state = kml_pkg::S_FIN;
                    endcase
                end
            end
            kml_pkg::S_MOD: begin
                // per key chunk: estimate the quotient, then subtract and correct
                if (r_bit[0]) begin
                    n_q = mod_prod[IW+47:IW+32];
                end else begin
                    n_mod = mod_r;
                end
                n_bit = r_bit - 1'b1;
                if (r_bit == 3'd0) begin
                    n_idx       = mod_r;
                    n_visit     = '0;
                    n_empty_vld = 1'b0;
                    n_state     = kml_pkg::S_PR_RD;
                end
            end
            kml_pkg::S_PR_RD: begin
                n_state = kml_pkg::S_PR_CHK;
            end
            kml_pkg::S_PR_CHK: begin
                if (slot_match) begin
                    n_slot   = r_idx;
                    n_scnt   = r_srd.cnt;
                    n_sflags = r_srd.flags;
                    n_j      = '0;
                    n_state  = kml_pkg::S_MV_RD;
                end else begin
                    if (is_fm && !r_empty_vld && r_srd.cnt == '0) begin
                        n_empty     = r_idx;
                        n_empty_vld = 1'b1;
                    end
                    if (!is_fm && r_srd.cnt == '0 && r_srd.key == '0) begin
                        n_st    = kml_pkg::ST_NOT_FOUND;
                        n_state = kml_pkg::S_FIN;
                    end else if (last_visit) begin
                        if (!is_fm) begin
                            n_st    = kml_pkg::ST_NOT_FOUND;
                            n_state = kml_pkg::S_FIN;
                        end else if (empty_ok) begin
                            // claim the first free slot for this key
                            n_slot     = empty_now;
                            n_scnt     = '0;
                            n_sflags   = '0;
                            slot_we    = 1'b1;
                            slot_waddr = empty_now;
                            slot_wdata = '{key: r_in.position_key, cnt: '0, flags: '0};
                            n_state    = kml_pkg::S_NOMV;
                        end else begin
                            n_st    = kml_pkg::ST_TABLE_FULL;
                            n_state = kml_pkg::S_FIN;
                        end
                    end else begin
                        n_idx   = idx_next;
                        n_visit = r_visit + 1'b1;
                        n_state = kml_pkg::S_PR_RD;
                    end
                end
            end
            kml_pkg::S_MV_RD: begin
                if (r_j >= r_scnt || r_j >= CW'(MOVES_PER_SLOT)) begin
                    n_state = kml_pkg::S_NOMV;
                end else begin
                    n_state = kml_pkg::S_MV_CHK;
                end
            end
            kml_pkg::S_MV_CHK: begin
                if (r_mrd.mv == r_in.move_code) begin
                    n_ent   = r_mrd;
                    n_state = kml_pkg::S_HIT;
                end else begin
                    n_j     = CW'(j_inc);
                    n_state = kml_pkg::S_MV_RD;
                end
            end
            kml_pkg::S_NOMV: begin
                n_state = kml_pkg::S_FIN;
                if (!is_fm) begin
                    n_st = kml_pkg::ST_NOT_FOUND;
                end else if (r_scnt >= CW'(MOVES_PER_SLOT)) begin
                    n_st = kml_pkg::ST_ENTRY_FULL;
                end else begin
                    // append at the end of the list
                    n_j    = r_scnt;
                    n_scnt = r_scnt + 1'b1;
                    if (r_in.op == kml_pkg::OP_LEARN) begin
                        n_ent   = '{mv: r_in.move_code, weight: kml_pkg::DEFAULT_WEIGHT,
                                    learn: '0, games: '0};
                        n_state = kml_pkg::S_LEARN_ADD;
                    end else begin
                        mv_we      = 1'b1;
                        mv_waddr   = MW'(r_slot) * MW'(MOVES_PER_SLOT) + MW'(r_scnt);
                        mv_wdata   = '{mv: r_in.move_code, weight: r_in.new_weight,
                                       learn: '0, games: '0};
                        slot_we    = 1'b1;
                        slot_wdata = '{key: r_in.position_key, cnt: r_scnt + 1'b1,
                                       flags: r_sflags | kml_pkg::FLAG_CUSTOM
                                              | kml_pkg::FLAG_MODIFIED};
                    end
                end
            end
            kml_pkg::S_HIT: begin
                n_state = kml_pkg::S_FIN;
                n_lv    = r_ent.learn;
                case (r_in.op)
                    kml_pkg::OP_LEARN: n_state = kml_pkg::S_LEARN_ADD;
                    kml_pkg::OP_ADD: begin
                        mv_we    = 1'b1;
                        mv_wdata = '{mv: r_ent.mv, weight: r_in.new_weight,
                                     learn: r_ent.learn, games: r_ent.games};
                    end
                    kml_pkg::OP_SET_WEIGHT: begin
                        mv_we      = 1'b1;
                        mv_wdata   = '{mv: r_ent.mv, weight: r_in.new_weight,
                                       learn: r_ent.learn, games: r_ent.games};
                        slot_we    = 1'b1;
                        slot_wdata.flags = r_sflags | kml_pkg::FLAG_MODIFIED;
                    end
                    kml_pkg::OP_REMOVE: begin
                        n_lv    = '0;
                        n_state = kml_pkg::S_RM_RD;
                    end
                    default: ;
                endcase
            end
            kml_pkg::S_LEARN_ADD: begin
                n_v     = (VW+2)'(signed'(r_ent.learn)) + delta;
                n_state = kml_pkg::S_LEARN_WR;
            end
            kml_pkg::S_LEARN_WR: begin
                mv_we      = 1'b1;
                mv_wdata   = '{mv: r_ent.mv, weight: r_ent.weight, learn: VW'(v_cl),
                               games: r_ent.games + 1'b1};
                slot_we    = 1'b1;
                slot_wdata.flags = r_sflags | kml_pkg::FLAG_MODIFIED;
                n_lv       = VW'(v_cl);
                n_state    = kml_pkg::S_FIN;
            end
            kml_pkg::S_RM_RD: begin
                mv_raddr = addr_j1;
                if (j_inc < {1'b0, r_scnt} && j_inc < (CW+1)'(MOVES_PER_SLOT)) begin
                    n_state = kml_pkg::S_RM_WR;
                end else begin
                    slot_we    = 1'b1;
                    slot_wdata = '{key: r_in.position_key, cnt: r_scnt - 1'b1,
                                   flags: r_sflags | kml_pkg::FLAG_MODIFIED};
                    n_state    = kml_pkg::S_FIN;
                end
            end
            kml_pkg::S_RM_WR: begin
                // shift the next move down one place
                mv_we    = 1'b1;
                mv_wdata = r_mrd;
                n_j      = CW'(j_inc);
                n_state  = kml_pkg::S_RM_RD;
            end
            kml_pkg::S_CLR_RD: begin
                n_state = kml_pkg::S_CLR_CHK;
            end
            kml_pkg::S_CLR_CHK: begin
                n_slot     = r_idx;
                n_scnt     = r_srd.cnt;
                n_j        = '0;
                slot_we    = 1'b1;
                slot_waddr = r_idx;
                slot_wdata = '{key: r_srd.key, cnt: r_srd.cnt,
                               flags: r_srd.flags & ~kml_pkg::FLAG_MODIFIED};
                n_state    = kml_pkg::S_CLR_MV;
            end
            kml_pkg::S_CLR_MV: begin
                if (r_j < r_scnt && r_j < CW'(MOVES_PER_SLOT)) begin
                    n_state = kml_pkg::S_CLR_MW;
                end else if (r_idx == IW'(SLOTS - 1)) begin
                    n_state = kml_pkg::S_FIN;
                end else begin
                    n_idx   = idx_next;
                    n_state = kml_pkg::S_CLR_RD;
                end
            end
            kml_pkg::S_CLR_MW: begin
                mv_we    = 1'b1;
                mv_wdata = '{mv: r_mrd.mv, weight: r_mrd.weight, learn: '0, games: '0};
                n_j      = CW'(j_inc);
                n_state  = kml_pkg::S_CLR_MV;
            end
            kml_pkg::S_FIN: begin
                // hold the result until the output register is free
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_out   = '{status: r_st, learn_value: r_lv};
                    n_state = kml_pkg::S_IDLE;
                end
            end
            default: n_state = kml_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kml_pkg::S_INIT;
            r_idx   <= '0;
            r_ov    <= 1'b0;
            r_en    <= 1'b1;
            r_win   <= 15'd10;
            r_loss  <= 15'd10;
            r_draw  <= '0;
            r_floor <= -16'sd100;
            r_ceil  <= 16'sd100;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    kml_pkg::CFG_ENABLE:  r_en    <= i_cfg_data[0];
                    kml_pkg::CFG_WIN:     r_win   <= i_cfg_data[14:0];
                    kml_pkg::CFG_LOSS:    r_loss  <= i_cfg_data[14:0];
                    kml_pkg::CFG_DRAW:    r_draw  <= i_cfg_data;
                    kml_pkg::CFG_FLOOR:   r_floor <= i_cfg_data;
                    kml_pkg::CFG_CEILING: r_ceil  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= n_in;           r_visit <= n_visit;   r_empty <= n_empty;
        r_empty_vld <= n_empty_vld;
        r_slot <= n_slot;       r_scnt <= n_scnt;     r_sflags <= n_sflags;
        r_j <= n_j;             r_ent <= n_ent;       r_v <= n_v;
        r_mod <= n_mod;         r_bit <= n_bit;       r_st <= n_st;
        r_lv <= n_lv;           r_out <= n_out;       r_q <= n_q;
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        r_srd <= slot_mem[slot_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (mv_we) begin
            move_mem[mv_waddr] <= mv_wdata;
        end
        r_mrd <= move_mem[mv_raddr];
    end

endmodule

// ----- hw/rtl/kml_checker.sv -----
// ----------------------------------------------------------------------------
// kml_checker: port-level checks of the keyed move learning table
// Result channel behavior and busy handling seen from the ports.
// ----------------------------------------------------------------------------
module kml_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_out_status,
    input logic [15:0] i_out_lv
);

    a_reset_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status)
            && $stable(i_out_lv))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready right after an accepted item");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_status <= kml_pkg::ST_DISABLED)
        else $error("undefined status code");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status == kml_pkg::ST_NOT_FOUND
            || i_out_status == kml_pkg::ST_TABLE_FULL
            || i_out_status == kml_pkg::ST_ENTRY_FULL
            || i_out_status == kml_pkg::ST_DISABLED) |-> i_out_lv == 16'd0)
        else $error("failed op returned a learn value");

endmodule

bind keyed_move_learning_table kml_checker u_kml_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.data.status),
    .i_out_lv     (o_out.data.learn_value)
);
